### hdl/dkvf_pkg.sv
// Shared constants and types for the deduplicating key/value queue.
`default_nettype none
package dkvf_pkg;

    // Parameter defaults
    localparam int DEPTH_DEF       = 16;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed port field widths
    localparam int FIELD_W = 32;
    localparam int IDX_W   = 5;
    localparam int STAT_W  = 2;
    localparam int WIDE_W  = 64;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_DUP   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd3;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic cmp;   // register the key compare for a new request
        logic shift; // take the neighbor's entry (pop)
        logic load;  // take the broadcast entry (push)
    } t_cell_ctl;

endpackage
`default_nettype wire

### hdl/dkvf_cell.sv
// One queue cell: holds one entry, compares its key, shifts toward the head.
`default_nettype none
module dkvf_cell #(
    parameter int KEY_WIDTH   = dkvf_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = dkvf_pkg::VALUE_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  dkvf_pkg::t_cell_ctl          i_ctl,
    input  wire                          i_live,
    input  wire  [KEY_WIDTH-1:0]         i_cmp_key,
    input  wire  [KEY_WIDTH-1:0]         i_load_key,
    input  wire  [VALUE_WIDTH-1:0]       i_load_value,
    input  wire  [dkvf_pkg::IDX_W-1:0]   i_load_index,
    input  wire  [KEY_WIDTH-1:0]         i_nb_key,
    input  wire  [VALUE_WIDTH-1:0]       i_nb_value,
    input  wire  [dkvf_pkg::IDX_W-1:0]   i_nb_index,
    output logic [KEY_WIDTH-1:0]         o_key,
    output logic [VALUE_WIDTH-1:0]       o_value,
    output logic [dkvf_pkg::IDX_W-1:0]   o_index,
    output logic                         o_match
);

    logic [KEY_WIDTH-1:0]       r_key;
    logic [VALUE_WIDTH-1:0]     r_value;
    logic [dkvf_pkg::IDX_W-1:0] r_index;
    logic                       r_match;

    // Entry storage: load on push, shift on pop
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key   <= i_load_key;
            r_value <= i_load_value;
            r_index <= i_load_index;
        end else if (i_ctl.shift) begin
            r_key   <= i_nb_key;
            r_value <= i_nb_value;
            r_index <= i_nb_index;
        end
    end

    // Registered key compare, only live cells can match
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_match <= i_live && (r_key == i_cmp_key);
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_index = r_index;
    assign o_match = r_match;

endmodule
`default_nettype wire

### hdl/dedup_key_value_fifo_unit.sv
// Top level of the deduplicating key/value queue: cell chain and sequencer.
//
// For each request, in the accepting cycle each cell compares
// its stored key with the request key and registers the outcome; in the
// next cycle (busy high) the match bits are ORed, the chain is loaded or
// shifted, and the result is registered. The result is on the output ports
// with o_done high for exactly one cycle, the cycle after busy, and must be
// taken then; a new request may be started in that same cycle, as busy is
// low again, and none is taken while busy is high. Entry 0 of the chain is
// always the oldest entry; pops shift every cell toward it.
`default_nettype none
module dedup_key_value_fifo_unit #(
    parameter int DEPTH       = dkvf_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH   = dkvf_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = dkvf_pkg::VALUE_WIDTH_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             start,
    output logic                            busy,
    input  wire                             i_operation,
    input  wire  [dkvf_pkg::FIELD_W-1:0]    i_key,
    input  wire  [dkvf_pkg::FIELD_W-1:0]    i_value,
    output logic                            o_done,
    output logic [dkvf_pkg::STAT_W-1:0]     o_status,
    output logic [dkvf_pkg::FIELD_W-1:0]    o_out_key,
    output logic [dkvf_pkg::FIELD_W-1:0]    o_out_value,
    output logic [dkvf_pkg::IDX_W-1:0]      o_out_index
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int FW    = dkvf_pkg::FIELD_W;
    localparam int WW    = dkvf_pkg::WIDE_W;
    localparam int IW    = dkvf_pkg::IDX_W;

    // Sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                  r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_op;
    logic [KEY_WIDTH-1:0]  r_key;
    logic [VALUE_WIDTH-1:0] r_value;

    logic                  r_done, n_done;
    logic [dkvf_pkg::STAT_W-1:0] r_status, n_status;
    logic [FW-1:0]         r_out_key, n_out_key;
    logic [FW-1:0]         r_out_value, n_out_value;
    logic [IW-1:0]         r_out_index, n_out_index;

    logic                  accept;
    logic [KEY_WIDTH-1:0]  in_key;
    logic [VALUE_WIDTH-1:0] in_value;
    logic                  any_match;
    logic                  push_ok;
    logic                  pop_ok;
    logic [31:0]           count_inc;
    logic [IW-1:0]         push_index;
    logic [WW-1:0]         head_key_wide;
    logic [WW-1:0]         head_value_wide;

    logic [KEY_WIDTH-1:0]   w_key   [DEPTH];
    logic [VALUE_WIDTH-1:0] w_value [DEPTH];
    logic [IW-1:0]          w_index [DEPTH];
    logic [DEPTH-1:0]       w_match;
    dkvf_pkg::t_cell_ctl    w_ctl   [DEPTH];
    logic [DEPTH-1:0]       w_live;

    assign accept = start && !busy;
    assign busy   = (r_state == ST_EXEC);

    // Fit request fields to the stored widths
    always_comb begin
        logic [WW-1:0] kw;
        logic [WW-1:0] vw;
        kw       = {{(WW-FW){1'b0}}, i_key};
        vw       = {{(WW-FW){1'b0}}, i_value};
        in_key   = kw[KEY_WIDTH-1:0];
        in_value = vw[VALUE_WIDTH-1:0];
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_key   <= in_key;
            r_value <= in_value;
        end
    end

    // Decision for the request in flight
    assign any_match  = |w_match;
    assign push_ok    = busy && (r_op == dkvf_pkg::OP_PUSH) && !any_match
                        && (r_count < CNT_W'(DEPTH));
    assign pop_ok     = busy && (r_op == dkvf_pkg::OP_POP) && (r_count != '0);
    assign count_inc  = 32'(r_count) + 32'd1;
    assign push_index = count_inc[IW-1:0];

    // Cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int NB = (g == DEPTH - 1) ? g : g + 1;

        assign w_live[g]      = (CNT_W'(g) < r_count);
        assign w_ctl[g].cmp   = accept;
        assign w_ctl[g].shift = pop_ok;
        assign w_ctl[g].load  = push_ok && (r_count == CNT_W'(g));

        dkvf_cell #(
            .KEY_WIDTH   (KEY_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl[g]),
            .i_live       (w_live[g]),
            .i_cmp_key    (in_key),
            .i_load_key   (r_key),
            .i_load_value (r_value),
            .i_load_index (push_index),
            .i_nb_key     (w_key[NB]),
            .i_nb_value   (w_value[NB]),
            .i_nb_index   (w_index[NB]),
            .o_key        (w_key[g]),
            .o_value      (w_value[g]),
            .o_index      (w_index[g]),
            .o_match      (w_match[g])
        );
    end

    assign head_key_wide   = WW'(w_key[0]);
    assign head_value_wide = WW'(w_value[0]);

    // Next state and result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_done      = 1'b0;
        n_status    = dkvf_pkg::STATUS_OK;
        n_out_key   = '0;
        n_out_value = '0;
        n_out_index = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                n_done  = 1'b1;
                if (r_op == dkvf_pkg::OP_PUSH) begin
                    if (any_match) begin
                        n_status = dkvf_pkg::STATUS_DUP;
                    end else if (!push_ok) begin
                        n_status = dkvf_pkg::STATUS_FULL;
                    end else begin
                        n_count     = r_count + CNT_W'(1);
                        n_out_index = push_index;
                    end
                end else begin
                    if (!pop_ok) begin
                        n_status = dkvf_pkg::STATUS_EMPTY;
                    end else begin
                        n_count     = r_count - CNT_W'(1);
                        n_out_key   = head_key_wide[FW-1:0];
                        n_out_value = head_value_wide[FW-1:0];
                        n_out_index = w_index[0];
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_out_key   <= n_out_key;
        r_out_value <= n_out_value;
        r_out_index <= n_out_index;
    end

    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_out_key   = r_out_key;
    assign o_out_value = r_out_value;
    assign o_out_index = r_out_index;

    // Checks
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == ST_EXEC))
        else $error("result strobe without an executing request");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == dkvf_pkg::STATUS_EMPTY) |-> ($past(r_count) == '0))
        else $error("empty status with live entries");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |=> ($stable(r_count) || !$past(busy)))
        else $error("entry count changed outside execution");

endmodule
`default_nettype wire

### verif/dedup_key_value_fifo_unit_tb.sv
// Testbench for the deduplicating key/value queue: directed and random requests.
`default_nettype none
module dedup_key_value_fifo_unit_tb;

    localparam int QDEPTH      = dkvf_pkg::DEPTH_DEF;
    localparam int HANG_CYCLES = 400;
    localparam int KEY_POOL_N  = 12;
    localparam int FW          = dkvf_pkg::FIELD_W;
    localparam int SW          = dkvf_pkg::STAT_W;
    localparam int IW          = dkvf_pkg::IDX_W;

    typedef struct packed {
        logic [SW-1:0] status;
        logic [FW-1:0] key;
        logic [FW-1:0] value;
        logic [IW-1:0] index;
    } t_outcome;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic          i_operation;
    logic [FW-1:0] i_key;
    logic [FW-1:0] i_value;
    logic          o_done;
    logic [SW-1:0] o_status;
    logic [FW-1:0] o_out_key;
    logic [FW-1:0] o_out_value;
    logic [IW-1:0] o_out_index;

    // Shadow copy of the queue contents
    logic [FW-1:0] shadow_keys   [QDEPTH];
    logic [FW-1:0] shadow_values [QDEPTH];
    logic [IW-1:0] shadow_tags   [QDEPTH];
    int unsigned   shadow_head;
    int unsigned   shadow_fill;

    t_outcome      awaited_outcomes[$];
    logic [FW-1:0] key_pool[KEY_POOL_N];
    int            error_count;
    int            stall_cycles;

    dedup_key_value_fifo_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_out_key   (o_out_key),
        .o_out_value (o_out_value),
        .o_out_index (o_out_index)
    );

    // Clock: 12 time unit period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Queue behavior: duplicate check wins over the full check
    function automatic t_outcome predict_outcome(logic op, logic [FW-1:0] key,
                                                 logic [FW-1:0] value);
        t_outcome    res;
        int unsigned slot;
        logic        hit;
        res  = '0;
        hit  = 1'b0;
        if (op == dkvf_pkg::OP_PUSH) begin
            for (int n = 0; n < shadow_fill; n++) begin
                if (shadow_keys[(shadow_head + n) % QDEPTH] == key)
                    hit = 1'b1;
            end
            if (hit) begin
                res.status = dkvf_pkg::STATUS_DUP;
            end else if (shadow_fill >= QDEPTH) begin
                res.status = dkvf_pkg::STATUS_FULL;
            end else begin
                slot = (shadow_head + shadow_fill) % QDEPTH;
                shadow_fill++;
                shadow_keys[slot]   = key;
                shadow_values[slot] = value;
                shadow_tags[slot]   = IW'(shadow_fill);
                res.status = dkvf_pkg::STATUS_OK;
                res.index  = IW'(shadow_fill);
            end
        end else if (shadow_fill == 0) begin
            res.status = dkvf_pkg::STATUS_EMPTY;
        end else begin
            res.status  = dkvf_pkg::STATUS_OK;
            res.key     = shadow_keys[shadow_head];
            res.value   = shadow_values[shadow_head];
            res.index   = shadow_tags[shadow_head];
            shadow_head = (shadow_head + 1) % QDEPTH;
            shadow_fill--;
        end
        return res;
    endfunction

    // Issue one request and hold it until the block takes it
    task automatic send_request(logic op, logic [FW-1:0] key, logic [FW-1:0] value);
        start       <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        i_value     <= value;
        do @(posedge i_clk); while (busy);
        awaited_outcomes.push_back(predict_outcome(op, key, value));
    endtask

    // Sender gap: mostly short, now and then long
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Hold off until every outstanding result has come back
    task automatic wait_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (awaited_outcomes.size() != 0);
    endtask

    // Key mostly from a small pool so duplicates are frequent
    function automatic logic [FW-1:0] pick_key();
        if ($urandom_range(0, 9) < 6)
            return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
        return $urandom;
    endfunction

    task automatic check_field(string name, logic [FW-1:0] exp_v, logic [FW-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Result checker: compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        t_outcome exp_o;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (awaited_outcomes.size() == 0) begin
                $display("%0t: unexpected result, expected none actual status %0d",
                         $time, o_status);
                error_count++;
            end else begin
                exp_o = awaited_outcomes.pop_front();
                check_field("status", FW'(exp_o.status), FW'(o_status));
                check_field("out_key", exp_o.key, o_out_key);
                check_field("out_value", exp_o.value, o_out_value);
                check_field("out_index", FW'(exp_o.index), FW'(o_out_index));
            end
        end
    end

    // Watchdog: cycles without an accepted request or a result
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((start && !busy) || o_done) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= HANG_CYCLES) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Edges of the fields, empty and full queue, duplicate while full
    task automatic test_directed();
        send_request(dkvf_pkg::OP_POP, 32'h0, 32'h0);
        send_request(dkvf_pkg::OP_PUSH, 32'h0, 32'h0);
        send_request(dkvf_pkg::OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(dkvf_pkg::OP_PUSH, 32'h0, 32'h1234_5678);
        send_request(dkvf_pkg::OP_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(dkvf_pkg::OP_POP, 32'h0, 32'h0);
        send_request(dkvf_pkg::OP_POP, 32'h0, 32'h0);
        for (int n = 0; n < QDEPTH; n++)
            send_request(dkvf_pkg::OP_PUSH, 32'h8000_0000 | n, ~n);
        send_request(dkvf_pkg::OP_PUSH, 32'h5555_AAAA, 32'hAAAA_5555);
        send_request(dkvf_pkg::OP_PUSH, 32'h8000_0003, 32'h0);
        wait_drain();
    endtask

    // Pause until the queue of results is empty, then pop the queue dry
    task automatic test_drain_pause();
        repeat (3) send_request(dkvf_pkg::OP_PUSH, $urandom, $urandom);
        wait_drain();
        repeat (QDEPTH + 4) send_request(dkvf_pkg::OP_POP, $urandom, $urandom);
        wait_drain();
        send_request(dkvf_pkg::OP_PUSH, key_pool[0], 32'h0);
        send_request(dkvf_pkg::OP_POP, 32'h0, 32'h0);
    endtask

    // Random phases with varying push bias and sender idling
    task automatic test_random_traffic();
        int push_pct;
        for (int phase = 0; phase < 26; phase++) begin
            push_pct = (phase % 3 == 0) ? 80 : ((phase % 3 == 1) ? 25 : 55);
            for (int n = 0; n < 50; n++) begin
                if ((phase % 4 != 2) && $urandom_range(0, 2) == 0)
                    idle_gap();
                if ($urandom_range(0, 99) < push_pct)
                    send_request(dkvf_pkg::OP_PUSH, pick_key(), $urandom);
                else
                    send_request(dkvf_pkg::OP_POP, $urandom, $urandom);
            end
            if (phase % 5 == 4)
                wait_drain();
        end
    endtask

    // Test sequence
    initial begin
        error_count  = 0;
        stall_cycles = 0;
        shadow_head  = 0;
        shadow_fill  = 0;
        key_pool[0]  = 32'h0;
        key_pool[1]  = 32'hFFFF_FFFF;
        key_pool[2]  = 32'h1;
        key_pool[3]  = 32'h8000_0000;
        for (int n = 4; n < KEY_POOL_N; n++)
            key_pool[n] = $urandom;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_operation <= dkvf_pkg::OP_PUSH;
        i_key       <= '0;
        i_value     <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_drain_pause();
        test_random_traffic();

        wait_drain();
        repeat (4) @(posedge i_clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire

### files.f
hdl/dkvf_pkg.sv
hdl/dkvf_cell.sv
hdl/dedup_key_value_fifo_unit.sv
verif/dedup_key_value_fifo_unit_tb.sv
